// ===== rtl/scl_pkg.sv =====
// Shared types and constants for the shape collision tester.
// Used by scl_cordic_iter and shape_collision_tester_core; no dependencies.
package scl_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int GUARD_BITS        = 8;
  localparam int ATAN_LEN          = 24;
  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

  typedef enum logic [2:0] {
    MODE_PT_CIRCLE     = 3'd0,
    MODE_PT_AABB       = 3'd1,
    MODE_PT_OBB        = 3'd2,
    MODE_CIRCLE_CIRCLE = 3'd3,
    MODE_AABB_AABB     = 3'd4,
    MODE_AABB_CIRCLE   = 3'd5,
    MODE_OBB_CIRCLE    = 3'd6
  } mode_e;

  // atan(2^-i) in units of pi/2^31
  function automatic logic [31:0] atan_lut(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/scl_cordic_iter.sv =====
// One rotation-mode CORDIC iteration (combinational).
// Depends on scl_pkg for the arctangent table.
module scl_cordic_iter import scl_pkg::*; #(
  parameter int XW  = 43,
  parameter int ZW  = 34,
  parameter int IDX = 0
) (
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] at;

  assign xs = x_i >>> IDX;
  assign ys = y_i >>> IDX;
  assign at = $signed(ZW'(atan_lut(IDX)));

  always_comb begin
    if (!en_i) begin
      x_o = x_i;
      y_o = y_i;
      z_o = z_i;
    end else if (z_i >= 0) begin
      x_o = x_i - ys;
      y_o = y_i + xs;
      z_o = z_i - at;
    end else begin
      x_o = x_i + ys;
      y_o = y_i - xs;
      z_o = z_i + at;
    end
  end

endmodule

// ===== rtl/shape_collision_tester_core.sv =====
// Shape collision tester: pipelined overlap test of two 2D shapes.
// Registers: offsets, guard bits and flip, one per CORDIC iteration, magnitude, gain
// correction, excess, split squares, compare. Throughput: one word per cycle while
// the sink accepts; stages stall individually, bubbles collapse.
// Reset: rst_ni (async, active low) clears all stage valid bits; no data state.
module shape_collision_tester_core import scl_pkg::*; #(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    mode_i,
  input  logic signed [COORD_WIDTH-1:0] pos_a_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_a_y_i,
  input  logic [COORD_WIDTH-2:0]        width_a_i,
  input  logic [COORD_WIDTH-2:0]        height_a_i,
  input  logic [COORD_WIDTH-2:0]        radius_a_i,
  input  logic signed [15:0]            angle_i,
  input  logic signed [COORD_WIDTH-1:0] pos_b_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_b_y_i,
  input  logic [COORD_WIDTH-2:0]        width_b_i,
  input  logic [COORD_WIDTH-2:0]        height_b_i,
  input  logic [COORD_WIDTH-2:0]        radius_b_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o
);

  localparam int W  = COORD_WIDTH;
  localparam int XW = W + GUARD_BITS + 3;
  localparam int EW = XW + 1;
  localparam int ZW = 34;
  localparam int SM = CORDIC_STAGES + 2;  // magnitude stage
  localparam int NS = CORDIC_STAGES + 9;
  localparam logic signed [31:0] HALF_PI = 32'sh40000000;
  localparam logic signed [ZW-1:0] PI_Z  = ZW'(64'sh80000000);

  // ---------------- flow control ----------------
  logic [NS-1:0] v_q;
  logic [NS:0]   adv;

  assign adv[NS] = out_ready_i;
  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv[k] = !v_q[k] || adv[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];

  // ---------------- sideband ----------------
  logic          orient_q [0:SM+2];
  logic          ok_q     [0:NS-2];
  logic [EW-1:0] w_q      [0:SM+2];
  logic [EW-1:0] h_q      [0:SM+2];
  logic [EW-1:0] r_q      [0:SM+2];

  // ---------------- stage 0: offsets, extents, angle ----------------
  logic signed [W:0]    dx_d, dy_d, dx_q, dy_q;
  logic [EW-1:0]        w_d, h_d, r_d;
  logic                 orient_d, ok_d, flip_d, flip_q;
  logic [15:0]          zn;
  logic signed [31:0]   zs;
  logic signed [ZW-1:0] ze, z0_d, z0_q;

  assign dx_d = $signed({pos_b_x_i[W-1], pos_b_x_i}) - $signed({pos_a_x_i[W-1], pos_a_x_i});
  assign dy_d = $signed({pos_b_y_i[W-1], pos_b_y_i}) - $signed({pos_a_y_i[W-1], pos_a_y_i});
  assign zn   = 16'(16'd0 - $unsigned(angle_i));
  assign zs   = $signed({zn, 16'h0000});
  assign ze   = ZW'(zs);

  always_comb begin
    w_d = '0;
    h_d = '0;
    r_d = '0;
    orient_d = 1'b0;
    ok_d = 1'b1;
    case (mode_i)
      MODE_PT_CIRCLE: r_d = EW'(radius_b_i);
      MODE_PT_AABB: begin
        w_d = EW'(width_a_i);
        h_d = EW'(height_a_i);
      end
      MODE_PT_OBB: begin
        w_d = EW'(width_a_i) << GUARD_BITS;
        h_d = EW'(height_a_i) << GUARD_BITS;
        orient_d = 1'b1;
      end
      MODE_CIRCLE_CIRCLE: r_d = EW'(radius_a_i) + EW'(radius_b_i);
      MODE_AABB_AABB: begin
        w_d = EW'(width_a_i) + EW'(width_b_i);
        h_d = EW'(height_a_i) + EW'(height_b_i);
      end
      MODE_AABB_CIRCLE: begin
        w_d = EW'(width_a_i);
        h_d = EW'(height_a_i);
        r_d = EW'(radius_b_i);
      end
      MODE_OBB_CIRCLE: begin
        w_d = EW'(width_a_i) << GUARD_BITS;
        h_d = EW'(height_a_i) << GUARD_BITS;
        r_d = EW'(radius_b_i) << GUARD_BITS;
        orient_d = 1'b1;
      end
      default: ok_d = 1'b0;
    endcase
  end

  // fold the target angle into [-pi/2, pi/2]; in oriented modes the vector flips with it
  always_comb begin
    flip_d = 1'b0;
    z0_d = ze;
    if (zs > HALF_PI) begin
      flip_d = orient_d;
      z0_d = ze - PI_Z;
    end else if (zs < -HALF_PI) begin
      flip_d = orient_d;
      z0_d = ze + PI_Z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      z0_q <= z0_d;
      flip_q <= flip_d;
    end
  end

  // sideband shift
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      orient_q[0] <= orient_d;
      ok_q[0] <= ok_d;
      w_q[0] <= w_d;
      h_q[0] <= h_d;
      r_q[0] <= r_d;
    end
    for (int k = 1; k <= SM + 2; k++) begin
      if (adv[k]) begin
        orient_q[k] <= orient_q[k-1];
        w_q[k] <= w_q[k-1];
        h_q[k] <= h_q[k-1];
        r_q[k] <= r_q[k-1];
      end
    end
    for (int k = 1; k <= NS - 2; k++) begin
      if (adv[k]) begin
        ok_q[k] <= ok_q[k-1];
      end
    end
  end

  // ---------------- stage 1: guard bits and flip ----------------
  logic signed [XW-1:0] x_q [1:SM-1];
  logic signed [XW-1:0] y_q [1:SM-1];
  logic signed [ZW-1:0] z_q [1:SM-1];
  logic signed [XW-1:0] xg, yg;

  assign xg = XW'(dx_q) <<< GUARD_BITS;
  assign yg = XW'(dy_q) <<< GUARD_BITS;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      x_q[1] <= flip_q ? -xg : xg;
      y_q[1] <= flip_q ? -yg : yg;
      z_q[1] <= z0_q;
    end
  end

  // ---------------- CORDIC iterations ----------------
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic signed [XW-1:0] xn, yn;
    logic signed [ZW-1:0] zn_i;

    scl_cordic_iter #(.XW(XW), .ZW(ZW), .IDX(i)) u_iter (
      .en_i (orient_q[i+1]),
      .x_i  (x_q[i+1]),
      .y_i  (y_q[i+1]),
      .z_i  (z_q[i+1]),
      .x_o  (xn),
      .y_o  (yn),
      .z_o  (zn_i)
    );

    always_ff @(posedge clk_i) begin
      if (adv[i+2]) begin
        x_q[i+2] <= xn;
        y_q[i+2] <= yn;
        z_q[i+2] <= zn_i;
      end
    end
  end

  // ---------------- magnitude ----------------
  logic [XW-1:0] absx, absy, mx_q, my_q;

  assign absx = (x_q[SM-1] < 0) ? XW'($unsigned(-x_q[SM-1])) : XW'($unsigned(x_q[SM-1]));
  assign absy = (y_q[SM-1] < 0) ? XW'($unsigned(-y_q[SM-1])) : XW'($unsigned(y_q[SM-1]));

  // axis-aligned modes carry the exact offset, guard bits dropped again
  always_ff @(posedge clk_i) begin
    if (adv[SM]) begin
      mx_q <= orient_q[SM-1] ? absx : (absx >> GUARD_BITS);
      my_q <= orient_q[SM-1] ? absy : (absy >> GUARD_BITS);
    end
  end

  // ---------------- gain correction, split 64x32 ----------------
  logic [63:0]   mx64, my64;
  logic [63:0]   plx_q, phx_q, ply_q, phy_q;
  logic [XW-1:0] mbx_q, mby_q;

  assign mx64 = 64'(mx_q);
  assign my64 = 64'(my_q);

  always_ff @(posedge clk_i) begin
    if (adv[SM+1]) begin
      plx_q <= {32'h0, mx64[31:0]} * {32'h0, INV_GAIN};
      phx_q <= {32'h0, mx64[63:32]} * {32'h0, INV_GAIN};
      ply_q <= {32'h0, my64[31:0]} * {32'h0, INV_GAIN};
      phy_q <= {32'h0, my64[63:32]} * {32'h0, INV_GAIN};
      mbx_q <= mx_q;
      mby_q <= my_q;
    end
  end

  logic [63:0]   gx, gy;
  logic [XW-1:0] ax_q, ay_q;

  assign gx = phx_q + {32'h0, plx_q[63:32]};
  assign gy = phy_q + {32'h0, ply_q[63:32]};

  always_ff @(posedge clk_i) begin
    if (adv[SM+2]) begin
      ax_q <= orient_q[SM+1] ? XW'(gx) : mbx_q;
      ay_q <= orient_q[SM+1] ? XW'(gy) : mby_q;
    end
  end

  // ---------------- excess over half extents ----------------
  logic [EW-1:0] tax, tay;
  logic [EW-1:0] e_q [0:2];

  assign tax = {ax_q, 1'b0};
  assign tay = {ay_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (adv[SM+3]) begin
      e_q[0] <= (tax > w_q[SM+2]) ? tax - w_q[SM+2] : '0;
      e_q[1] <= (tay > h_q[SM+2]) ? tay - h_q[SM+2] : '0;
      e_q[2] <= {r_q[SM+2][EW-2:0], 1'b0};
    end
  end

  // ---------------- squares, split into 32-bit partials ----------------
  logic [63:0]  ll_q [0:2];
  logic [63:0]  lh_q [0:2];
  logic [63:0]  hh_q [0:2];
  logic [127:0] s_q  [0:2];

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      if (adv[SM+4]) begin
        ll_q[j] <= 64'(e_q[j][31:0]) * 64'(e_q[j][31:0]);
        lh_q[j] <= 64'(e_q[j][31:0]) * (64'(e_q[j]) >> 32);
        hh_q[j] <= (64'(e_q[j]) >> 32) * (64'(e_q[j]) >> 32);
      end
      if (adv[SM+5]) begin
        s_q[j] <= 128'(ll_q[j]) + (128'(lh_q[j]) << 33) + (128'(hh_q[j]) << 64);
      end
    end
  end

  // ---------------- compare ----------------
  logic hit_q;

  always_ff @(posedge clk_i) begin
    if (adv[NS-1]) begin
      hit_q <= ok_q[NS-2] && ((s_q[0] + s_q[1]) <= s_q[2]);
    end
  end

  assign hit_o = hit_q;

`ifndef NO_ASSERTIONS
  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

  a_sink_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while sink takes words");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ($countones(v_q) == NS))
    else $error("input stalled with a bubble in the pipeline");
`endif

endmodule

// ===== bench/tb_shape_collision_tester_core.sv =====
// Testbench for shape_collision_tester_core: directed table then random queries,
// every accepted word checked against a fixed expectation or a bit-exact overlap predictor.
// Depends on scl_pkg (mode_e, GUARD_BITS, INV_GAIN) and the RTL top level only.
`timescale 1ns / 100ps

module tb_shape_collision_tester_core import scl_pkg::*; ();

  localparam int          STAGES      = 16;
  localparam int          LATENCY     = STAGES + 9;
  localparam int          N_RANDOM    = 1600;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam logic [2:0]  MODE_UNUSED = 3'd7;
  localparam logic [30:0] LEN_MAX     = 31'h7FFFFFFF;
  localparam logic [31:0] CRD_MAX     = 32'h7FFFFFFF;
  localparam logic [31:0] CRD_MIN     = 32'h80000000;
  localparam int          EXP_PRED    = -1;

  typedef struct {
    logic [2:0]         mode;
    logic signed [31:0] ax, ay;
    logic [30:0]        wa, ha, ra;
    logic signed [15:0] ang;
    logic signed [31:0] bx, by;
    logic [30:0]        wb, hb, rb;
  } query_t;

  typedef struct {
    query_t q;
    int     exp;
  } row_t;

  logic clk, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i, hit_o;
  logic [2:0] mode_i;
  logic signed [31:0] pos_a_x_i, pos_a_y_i, pos_b_x_i, pos_b_y_i;
  logic [30:0] width_a_i, height_a_i, radius_a_i, width_b_i, height_b_i, radius_b_i;
  logic signed [15:0] angle_i;

  bit   hit_q[$];
  int   errors = 0;
  int   cycles = 0;
  int   n_hits = 0, n_results = 0;
  int   mode_cnt[8];
  bit   calm = 0;
  int   stall_left = 0;
  row_t rows[$];

  shape_collision_tester_core uut (
    .clk_i(clk), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .mode_i(mode_i), .pos_a_x_i(pos_a_x_i), .pos_a_y_i(pos_a_y_i),
    .width_a_i(width_a_i), .height_a_i(height_a_i), .radius_a_i(radius_a_i),
    .angle_i(angle_i), .pos_b_x_i(pos_b_x_i), .pos_b_y_i(pos_b_y_i),
    .width_b_i(width_b_i), .height_b_i(height_b_i), .radius_b_i(radius_b_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .hit_o(hit_o)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------- predictor ----------------
  function automatic logic [63:0] atan_val(int i);
    logic [31:0] t[24];
    t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
          32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
          32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
          32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
          32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    return {32'b0, t[i]};
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [127:0] square(logic [63:0] v);
    return {64'b0, v} * {64'b0, v};
  endfunction

  // offset a,b against full extents w,h and radius r, all exact
  function automatic bit overlaps(logic [63:0] ax, logic [63:0] ay,
                                  logic [63:0] w, logic [63:0] h, logic [63:0] r);
    logic [63:0] ex, ey;
    ex = (2 * ax > w) ? 2 * ax - w : 64'd0;
    ey = (2 * ay > h) ? 2 * ay - h : 64'd0;
    return (square(ex) + square(ey)) <= square(2 * r);
  endfunction

  // truncated product with the inverse CORDIC gain
  function automatic logic [63:0] unscale(logic signed [63:0] v);
    logic [127:0] p;
    p = {64'b0, abs64(v)} * {96'b0, INV_GAIN};
    return p[95:32];
  endfunction

  function automatic void derotate(input logic signed [63:0] dx,
                                   input logic signed [63:0] dy,
                                   input logic signed [15:0] ang,
                                   output logic [63:0] mx, output logic [63:0] my);
    logic signed [63:0] x, y, z, xs, ys;
    logic [15:0] na;
    x = dx <<< GUARD_BITS;
    y = dy <<< GUARD_BITS;
    na = -ang;
    z = {32'b0, na, 16'b0};
    if (z >= 64'sh80000000) z = z - 64'sh100000000;
    if (z > 64'sh40000000) begin
      x = -x; y = -y; z = z - 64'sh80000000;
    end else if (z < -64'sh40000000) begin
      x = -x; y = -y; z = z + 64'sh80000000;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - $signed(atan_val(i));
      end else begin
        x = x + ys; y = y - xs; z = z + $signed(atan_val(i));
      end
    end
    mx = unscale(x);
    my = unscale(y);
  endfunction

  function automatic bit predict_hit(query_t q);
    logic signed [63:0] ax, ay, bx, by, dx, dy;
    logic [63:0] mx, my, wa, ha, wb, hb, ra, rb;
    ax = q.ax; ay = q.ay; bx = q.bx; by = q.by;
    wa = q.wa; ha = q.ha; wb = q.wb; hb = q.hb; ra = q.ra; rb = q.rb;
    dx = bx - ax;
    dy = by - ay;
    mx = abs64(dx);
    my = abs64(dy);
    case (q.mode)
      MODE_PT_CIRCLE:     return overlaps(mx, my, 0, 0, rb);
      MODE_PT_AABB:       return overlaps(mx, my, wa, ha, 0);
      MODE_PT_OBB: begin
        derotate(dx, dy, q.ang, mx, my);
        return overlaps(mx, my, wa << GUARD_BITS, ha << GUARD_BITS, 0);
      end
      MODE_CIRCLE_CIRCLE: return overlaps(mx, my, 0, 0, ra + rb);
      MODE_AABB_AABB:     return overlaps(mx, my, wa + wb, ha + hb, 0);
      MODE_AABB_CIRCLE:   return overlaps(mx, my, wa, ha, rb);
      MODE_OBB_CIRCLE: begin
        derotate(dx, dy, q.ang, mx, my);
        return overlaps(mx, my, wa << GUARD_BITS, ha << GUARD_BITS, rb << GUARD_BITS);
      end
      default:            return 1'b0;
    endcase
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic query_t mkq(logic [2:0] m, logic [31:0] ax, logic [31:0] ay,
                                 logic [30:0] wa, logic [30:0] ha, logic [30:0] ra,
                                 logic [15:0] ang, logic [31:0] bx, logic [31:0] by,
                                 logic [30:0] wb, logic [30:0] hb, logic [30:0] rb);
    query_t q;
    q.mode = m; q.ax = ax; q.ay = ay; q.wa = wa; q.ha = ha; q.ra = ra; q.ang = ang;
    q.bx = bx; q.by = by; q.wb = wb; q.hb = hb; q.rb = rb;
    return q;
  endfunction

  task automatic add_row(query_t q, int e);
    row_t r;
    r.q = q; r.exp = e;
    rows.push_back(r);
  endtask

  function automatic logic [31:0] pick_span();
    return 32'd1 << $urandom_range(2, 29);
  endfunction

  function automatic logic [30:0] pick_len(logic [31:0] span);
    case ($urandom_range(0, 9))
      0: return 31'($urandom);
      1: return '0;
      2: return LEN_MAX;
      default: return 31'($urandom % span);
    endcase
  endfunction

  function automatic logic [31:0] pick_near(logic [31:0] c, logic [31:0] span);
    if ($urandom_range(0, 15) == 0) return $urandom;
    return c + ($urandom % (2 * span)) - span;
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h4000;
      2: return 16'hC000;
      3: return 16'h8000;
      4: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic query_t random_query();
    query_t q;
    logic [31:0] span, cx, cy;
    span = pick_span();
    if ($urandom_range(0, 3) == 0) begin
      cx = $urandom; cy = $urandom;
    end else begin
      cx = $urandom % 32'h20000000 - 32'h10000000;
      cy = $urandom % 32'h20000000 - 32'h10000000;
    end
    q.mode = ($urandom_range(0, 39) == 0) ? MODE_UNUSED : 3'($urandom_range(0, 6));
    q.ax = cx; q.ay = cy;
    q.wa = pick_len(span); q.ha = pick_len(span); q.ra = pick_len(span);
    q.wb = pick_len(span); q.hb = pick_len(span); q.rb = pick_len(span);
    q.ang = pick_angle();
    q.bx = pick_near(cx, span);
    q.by = pick_near(cy, span);
    return q;
  endfunction

  function automatic int pick_gap();
    int k;
    if (calm) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic send(query_t q, int e);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mode_i <= q.mode; pos_a_x_i <= q.ax; pos_a_y_i <= q.ay;
    width_a_i <= q.wa; height_a_i <= q.ha; radius_a_i <= q.ra; angle_i <= q.ang;
    pos_b_x_i <= q.bx; pos_b_y_i <= q.by;
    width_b_i <= q.wb; height_b_i <= q.hb; radius_b_i <= q.rb;
    in_valid_i <= 1'b1;
    do @(posedge clk); while (!in_ready_o);
    hit_q.push_back((e == EXP_PRED) ? predict_hit(q) : e[0]);
    mode_cnt[q.mode]++;
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
    errors++;
  endtask

  // ---------------- receiver side ----------------
  always @(posedge clk) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0:       begin stall_left <= $urandom_range(5, 40); out_ready_i <= 1'b0; end
        1, 2, 3: out_ready_i <= 1'b0;
        default: out_ready_i <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (hit_q.size() == 0) begin
        report("unexpected word, hit", hit_o, 0);
      end else begin
        if (hit_o !== hit_q[0]) report("hit", hit_o, hit_q[0]);
        n_hits += hit_q[0];
        void'(hit_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, hit_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    in_valid_i = 1'b0; mode_i = '0; pos_a_x_i = '0; pos_a_y_i = '0;
    width_a_i = '0; height_a_i = '0; radius_a_i = '0; angle_i = '0;
    pos_b_x_i = '0; pos_b_y_i = '0; width_b_i = '0; height_b_i = '0; radius_b_i = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // directed: coincident points, degenerate shapes, inclusive edges, extremes
    add_row(mkq(MODE_PT_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
    add_row(mkq(MODE_PT_CIRCLE, 0, 0, 0, 0, 0, 0, 3, 4, 0, 0, 5), 1);
    add_row(mkq(MODE_PT_CIRCLE, 0, 0, 0, 0, 0, 0, 3, 4, 0, 0, 4), 0);
    add_row(mkq(MODE_PT_AABB, 0, 0, 2, 2, 0, 0, 1, 1, 0, 0, 0), 1);
    add_row(mkq(MODE_PT_AABB, 0, 0, 2, 2, 0, 0, 2, 1, 0, 0, 0), 0);
    add_row(mkq(MODE_PT_AABB, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
    add_row(mkq(MODE_PT_OBB, 0, 0, 31'h20000, 31'h20000, 0, 16'h2000,
                32'hC000, 32'hC000, 0, 0, 0), EXP_PRED);
    add_row(mkq(MODE_PT_OBB, CRD_MIN, CRD_MIN, LEN_MAX, LEN_MAX, 0, 16'h8000,
                CRD_MAX, CRD_MAX, 0, 0, 0), EXP_PRED);
    add_row(mkq(MODE_CIRCLE_CIRCLE, CRD_MIN, 0, 0, 0, 0, 0, CRD_MAX, 0, 0, 0, 0), 0);
    add_row(mkq(MODE_CIRCLE_CIRCLE, CRD_MIN, 0, 0, 0, LEN_MAX, 0, CRD_MAX, 0, 0, 0,
                LEN_MAX), 0);
    add_row(mkq(MODE_CIRCLE_CIRCLE, 0, 0, 0, 0, 1, 0, 0, 5, 0, 0, 4), 1);
    add_row(mkq(MODE_AABB_AABB, 0, 0, 2, 2, 0, 0, 2, 0, 2, 2, 0), 1);
    add_row(mkq(MODE_AABB_AABB, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
    add_row(mkq(MODE_AABB_AABB, CRD_MIN, CRD_MIN, LEN_MAX, LEN_MAX, 0, 0,
                CRD_MAX, CRD_MAX, LEN_MAX, LEN_MAX, 0), EXP_PRED);
    add_row(mkq(MODE_AABB_CIRCLE, 0, 0, 2, 2, 0, 0, 4, 5, 0, 0, 5), 1);
    add_row(mkq(MODE_AABB_CIRCLE, 0, 0, 2, 2, 0, 0, 4, 5, 0, 0, 4), 0);
    add_row(mkq(MODE_OBB_CIRCLE, 0, 0, 31'h40000, 31'h10000, 0, 16'h4000,
                0, 32'h18000, 0, 0, 31'h1000), EXP_PRED);
    add_row(mkq(MODE_OBB_CIRCLE, CRD_MAX, CRD_MIN, LEN_MAX, LEN_MAX, 0, 16'h7FFF,
                CRD_MIN, CRD_MAX, 0, 0, LEN_MAX), EXP_PRED);
    add_row(mkq(MODE_OBB_CIRCLE, 0, 0, 31'h30000, 31'h30000, 0, 16'hC000,
                32'h1000, 32'h2000, 0, 0, 0), EXP_PRED);
    add_row(mkq(MODE_UNUSED, 0, 0, LEN_MAX, LEN_MAX, LEN_MAX, 0, 0, 0, LEN_MAX,
                LEN_MAX, LEN_MAX), 0);
    add_row(mkq(MODE_UNUSED, CRD_MIN, CRD_MAX, LEN_MAX, 0, LEN_MAX, 16'h8000,
                CRD_MAX, CRD_MIN, 0, LEN_MAX, 0), 0);
    foreach (rows[i]) send(rows[i].q, rows[i].exp);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 200 == 0) calm = ($urandom_range(0, 2) == 0);
      if (n == N_RANDOM / 2) begin
        // hold off until the pipe has drained completely
        in_valid_i <= 1'b0;
        @(posedge clk);
        while (hit_q.size() != 0) @(posedge clk);
      end
      send(random_query(), EXP_PRED);
    end
    in_valid_i <= 1'b0;

    while (hit_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    $display("covered %0d results (%0d hits), per mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             n_results, n_hits, mode_cnt[0], mode_cnt[1], mode_cnt[2], mode_cnt[3],
             mode_cnt[4], mode_cnt[5], mode_cnt[6], mode_cnt[7]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
